[rtl/core/p2d_pkg.sv]
`timescale 1ns / 1ps

package p2d_pkg;

  localparam int DEF_STORE_DEPTH = 4096;
  localparam int NUM_W = 25;
  localparam int DEN_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int EMPTY_MAX_SEED = -129;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_PULL = 1'b1
  } op_t;

  typedef enum logic {
    MODE_MAX = 1'b0,
    MODE_AVG = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 3'd0,
    CFG_CHANNELS = 3'd1,
    CFG_IN_SIZE  = 3'd2,
    CFG_OUT_SIZE = 3'd3,
    CFG_KERNEL   = 3'd4,
    CFG_STRIDE   = 3'd5,
    CFG_PAD      = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    op_t              operation;
    logic signed [7:0] sample;
  } item_t;

  typedef struct packed {
    logic signed [7:0] value;
    logic              empty_window;
    logic              last;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TOT1,
    S_TOT2,
    S_CHECK,
    S_DIVA,
    S_DIVB,
    S_DIVC,
    S_DIVD,
    S_WIN1,
    S_WIN2,
    S_WIN3,
    S_WIN4,
    S_ADDR,
    S_SCAN,
    S_DRAIN,
    S_AVG,
    S_FIN
  } state_t;

endpackage

[rtl/core/pool_2d_q7_hwc_top.sv]
`timescale 1ns / 1ps
// A load transaction produces no result. A pull blocks further transactions until its
// result has been presented; it scans each in-map window sample, and average mode adds a
// serial division. A window with no in-map samples and an overrun pull skip the scan. The
// first pull after a register write first recomputes the output position and address steps;
// a store depth that is not a power of two lengthens that and every pull with samples.
// Synchronous active-high reset clears the state, the output and load indices, the result
// valid flag and the configuration registers; the store is not cleared.
module pool_2d_q7_hwc_top #(
  parameter int STORE_DEPTH = p2d_pkg::DEF_STORE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  p2d_pkg::item_t                       item,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output p2d_pkg::result_t                     result,
  input  logic                                 cfg_we,
  input  logic [p2d_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [p2d_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import p2d_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam bit POW2 = (STORE_DEPTH & (STORE_DEPTH - 1)) == 0;
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(STORE_DEPTH);
  localparam int RSH = NUM_W + AW;
  localparam logic [63:0] RMUL64 =
    ((64'd1 << RSH) + 64'(STORE_DEPTH) - 64'd1) / 64'(STORE_DEPTH);
  localparam logic [NUM_W:0] RMUL = (NUM_W + 1)'(RMUL64);

  logic [7:0] store [STORE_DEPTH];

  state_t state, state_next;

  mode_t       mode_r;
  logic [7:0]  channels_r;
  logic [15:0] in_size_r, out_size_r, kernel_r, stride_r, pad_r;

  logic [15:0] prod, rowp, t;
  logic [23:0] total, idx, pos;
  logic [7:0]  c, ox, oy;
  logic [AW-1:0] chm, rowm, addr, row_addr, load_index;
  logic [15:0] mx, my;
  logic [7:0]  xlo, xhi, ylo, yhi, kx, ky;
  logic        empty_r, ovr, dirty, entered, pend;
  logic [NUM_W-1:0] n1;
  logic signed [7:0] best, avg_q, rdata;
  logic signed [NUM_W-1:0] sum;
  logic [DEN_W-1:0] cnt;

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0] div_den, div_rem;
  logic [AW-1:0]    mod_val;
  logic             mod_ready;

  logic [2*NUM_W:0] red_prod;
  logic [NUM_W-1:0] red_q, red_quot, red_back;
  logic [AW-1:0]    red_r;
  logic [1:0]       red_age;

  logic item_acc, out_free, last_out;
  logic signed [17:0] xs, xe, ys, ye, xl, xh, yl, yh;
  logic ex, ey;
  logic [AW-1:0] addr_step, row_step;
  logic [AW:0]   addr_sum, row_sum;

  p2d_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  assign item_acc = item_valid && !item_stall;
  assign out_free = !result_valid || !result_stall;
  assign last_out = ovr || (idx == total - 24'd1);

  always_comb begin
    xs = 18'(signed'({2'b00, mx})) - 18'(signed'({10'd0, pad_r[7:0]}));
    xe = xs + 18'(signed'({10'd0, kernel_r[7:0]}));
    ys = 18'(signed'({2'b00, my})) - 18'(signed'({10'd0, pad_r[15:8]}));
    ye = ys + 18'(signed'({10'd0, kernel_r[15:8]}));
    xl = (xs < 0) ? 18'sd0 : xs;
    yl = (ys < 0) ? 18'sd0 : ys;
    xh = (xe > 18'(signed'({10'd0, in_size_r[7:0]}))) ? 18'(signed'({10'd0, in_size_r[7:0]})) : xe;
    yh = (ye > 18'(signed'({10'd0, in_size_r[15:8]}))) ? 18'(signed'({10'd0, in_size_r[15:8]})) : ye;
    ex = xh <= xl;
    ey = yh <= yl;
  end

  always_comb begin
    addr_sum  = {1'b0, addr} + {1'b0, chm};
    addr_step = (addr_sum >= DEPTH_W) ? AW'(addr_sum - DEPTH_W) : addr_sum[AW-1:0];
    row_sum   = {1'b0, row_addr} + {1'b0, rowm};
    row_step  = (row_sum >= DEPTH_W) ? AW'(row_sum - DEPTH_W) : row_sum[AW-1:0];
  end

  always_comb begin
    red_prod = (2*NUM_W+1)'(div_num) * (2*NUM_W+1)'(RMUL);
    red_quot = NUM_W'(red_prod >> RSH);
    red_back = red_q * NUM_W'(STORE_DEPTH);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (item_acc && item.operation == OP_PULL) state_next = S_TOT1;
      S_TOT1:  state_next = S_TOT2;
      S_TOT2:  state_next = S_CHECK;
      S_CHECK: begin
        if (total == 24'd0 || idx >= total) state_next = S_FIN;
        else if (dirty) state_next = S_DIVA;
        else state_next = S_WIN1;
      end
      S_DIVA:  if (div_done) state_next = S_DIVB;
      S_DIVB:  if (div_done) state_next = S_DIVC;
      S_DIVC:  if (mod_ready) state_next = S_DIVD;
      S_DIVD:  if (mod_ready) state_next = S_WIN1;
      S_WIN1:  state_next = S_WIN2;
      S_WIN2:  state_next = (ex || ey) ? S_FIN : S_WIN3;
      S_WIN3:  state_next = S_WIN4;
      S_WIN4:  state_next = S_ADDR;
      S_ADDR:  if (mod_ready) state_next = S_SCAN;
      S_SCAN:  if (kx == xhi - 8'd1 && ky == yhi - 8'd1) state_next = S_DRAIN;
      S_DRAIN: state_next = (mode_r == MODE_AVG) ? S_AVG : S_FIN;
      S_AVG:   if (div_done) state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item_stall = state != S_IDLE;
    div_num    = '0;
    div_den    = DEN_W'(STORE_DEPTH);
    unique case (state)
      S_DIVA: begin
        div_num = NUM_W'(idx);
        div_den = DEN_W'(channels_r);
      end
      S_DIVB: begin
        div_num = NUM_W'(pos);
        div_den = DEN_W'(out_size_r[7:0]);
      end
      S_DIVC: div_num = NUM_W'(channels_r);
      S_DIVD: div_num = NUM_W'(rowp);
      S_ADDR: div_num = n1 + NUM_W'(c);
      S_AVG: begin
        div_num = (sum < 0) ? NUM_W'(-sum) : NUM_W'(sum);
        div_den = cnt;
      end
      default: div_num = '0;
    endcase
    div_start = entered && (state == S_DIVA || state == S_DIVB || state == S_AVG);
    mod_val   = POW2 ? div_num[AW-1:0] : red_r;
    mod_ready = POW2 || (!entered && red_age == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (item_acc && item.operation == OP_LOAD) begin
      store[load_index] <= item.sample;
    end
    rdata <= store[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entered      <= 1'b0;
      pend         <= 1'b0;
      dirty        <= 1'b1;
      result_valid <= 1'b0;
      idx          <= '0;
      c            <= '0;
      ox           <= '0;
      oy           <= '0;
      load_index   <= '0;
      red_age      <= '0;
      mode_r       <= MODE_MAX;
      channels_r   <= 8'd1;
      in_size_r    <= 16'd257;
      out_size_r   <= 16'd257;
      kernel_r     <= 16'd257;
      stride_r     <= 16'd257;
      pad_r        <= 16'd0;
    end else begin
      state   <= state_next;
      entered <= state_next != state;
      pend    <= state == S_SCAN;

      red_q <= red_quot;
      red_r <= AW'(div_num - red_back);
      if (entered) red_age <= 2'd1;
      else if (red_age != 2'd2) red_age <= red_age + 2'd1;

      if (cfg_we) begin
        dirty <= 1'b1;
        unique case (cfg_index)
          CFG_MODE:     mode_r <= mode_t'(cfg_data[0]);
          CFG_CHANNELS: channels_r <= cfg_data[7:0];
          CFG_IN_SIZE:  in_size_r <= cfg_data;
          CFG_OUT_SIZE: out_size_r <= cfg_data;
          CFG_KERNEL:   kernel_r <= cfg_data;
          CFG_STRIDE:   stride_r <= cfg_data;
          CFG_PAD:      pad_r <= cfg_data;
          default: ;
        endcase
      end

      if (result_valid && !result_stall) result_valid <= 1'b0;

      if (item_acc && item.operation == OP_LOAD) begin
        load_index <= (load_index == AW'(STORE_DEPTH - 1)) ? '0 : load_index + 1'b1;
      end

      unique case (state)
        S_TOT1: begin
          prod <= channels_r * out_size_r[7:0];
          rowp <= channels_r * in_size_r[7:0];
        end
        S_TOT2: total <= prod * out_size_r[15:8];
        S_CHECK: begin
          ovr     <= total == 24'd0 || idx >= total;
          empty_r <= 1'b1;
        end
        S_DIVA: if (div_done) begin
          c   <= div_rem[7:0];
          pos <= div_quot[23:0];
        end
        S_DIVB: if (div_done) begin
          ox <= div_rem[7:0];
          oy <= div_quot[7:0];
        end
        S_DIVC: if (mod_ready) chm <= mod_val;
        S_DIVD: if (mod_ready) begin
          rowm  <= mod_val;
          dirty <= 1'b0;
        end
        S_WIN1: begin
          mx <= ox * stride_r[7:0];
          my <= oy * stride_r[15:8];
        end
        S_WIN2: begin
          empty_r <= ex || ey;
          xlo     <= xl[7:0];
          xhi     <= xh[7:0];
          ylo     <= yl[7:0];
          yhi     <= yh[7:0];
        end
        S_WIN3: begin
          t  <= ylo * in_size_r[7:0];
          kx <= xlo;
          ky <= ylo;
        end
        S_WIN4: n1 <= channels_r * (17'(t) + 17'(xlo));
        S_ADDR: begin
          best <= -8'sd128;
          sum  <= '0;
          cnt  <= '0;
          if (mod_ready) begin
            addr     <= mod_val;
            row_addr <= mod_val;
          end
        end
        S_SCAN: begin
          if (kx == xhi - 8'd1) begin
            kx       <= xlo;
            ky       <= ky + 8'd1;
            row_addr <= row_step;
            addr     <= row_step;
          end else begin
            kx   <= kx + 8'd1;
            addr <= addr_step;
          end
        end
        S_AVG: if (div_done) begin
          avg_q <= (sum < 0) ? -signed'(div_quot[7:0]) : signed'(div_quot[7:0]);
        end
        S_FIN: if (out_free) begin
          result_valid        <= 1'b1;
          result.empty_window <= empty_r;
          result.last         <= last_out;
          if (ovr) result.value <= 8'sd0;
          else if (empty_r) result.value <= (mode_r == MODE_AVG) ? 8'sd0 : 8'(EMPTY_MAX_SEED);
          else result.value <= (mode_r == MODE_AVG) ? avg_q : best;
          if (last_out) begin
            idx        <= '0;
            c          <= '0;
            ox         <= '0;
            oy         <= '0;
            load_index <= '0;
          end else begin
            idx <= idx + 24'd1;
            if (c == channels_r - 8'd1) begin
              c <= '0;
              if (ox == out_size_r[7:0] - 8'd1) begin
                ox <= '0;
                oy <= oy + 8'd1;
              end else begin
                ox <= ox + 8'd1;
              end
            end else begin
              c <= c + 8'd1;
            end
          end
        end
        default: ;
      endcase

      if (pend) begin
        if (rdata > best) best <= rdata;
        sum <= sum + NUM_W'(rdata);
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

[rtl/core/p2d_div.sv]
`timescale 1ns / 1ps

module p2d_div #(
  parameter int NW = p2d_pkg::NUM_W,
  parameter int DW = p2d_pkg::DEN_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);
  import p2d_pkg::*;

  localparam int CW = $clog2(NW);

  logic          running;
  logic [CW-1:0] cnt;
  logic [NW-1:0] q;
  logic [DW-1:0] r;
  logic [DW:0]   rs;
  logic          ge;
  logic [DW-1:0] r_next;
  logic [NW-1:0] q_next;

  always_comb begin
    rs     = {r, q[NW-1]};
    ge     = rs >= {1'b0, den};
    r_next = ge ? DW'(rs - {1'b0, den}) : rs[DW-1:0];
    q_next = {q[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q       <= num;
        r       <= '0;
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        q   <= q_next;
        r   <= r_next;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quot = q;
  assign rem  = r;

endmodule

[rtl/core/p2d_chk.sv]
`timescale 1ns / 1ps

module p2d_chk (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input p2d_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input p2d_pkg::result_t result
);
  import p2d_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("Stalled result transaction changed.");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("Result valid right after reset.");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.operation == OP_LOAD && !result_valid |=> !result_valid)
    else $error("Load transaction produced a result.");

  a_pull_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.operation == OP_PULL |=> item_stall)
    else $error("Block took a new transaction while a pull was in progress.");

endmodule

bind pool_2d_q7_hwc_top p2d_chk u_p2d_chk (.*);

[verif/tb_pool_2d_q7_hwc_top.sv]
`timescale 1ns / 1ps

module tb_pool_2d_q7_hwc_top;
  import p2d_pkg::*;

  localparam int DEPTH = DEF_STORE_DEPTH;
  localparam int CYCLE_LIMIT = 6000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pool_2d_q7_hwc_top i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Local copy of the block state.
  logic signed [7:0] feat_mem [DEPTH];
  int unsigned load_ptr, out_ptr;
  mode_t pool_mode;
  logic [7:0] chan_reg;
  logic [15:0] in_reg, out_reg, kern_reg, strd_reg, pad_reg;

  item_t pending_items[$];
  result_t pooled_expect[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int errors = 0;
  int unsigned cycles = 0;

  function automatic result_t pool_pull();
    int ch, ow, oh, total, idx, c, pos, ox, oy, iw, ih;
    int xlo, xhi, ylo, yhi, best, sum, cnt, res, st, kw, kh;
    result_t r;
    ch = chan_reg;
    ow = out_reg[7:0];
    oh = out_reg[15:8];
    total = ch * ow * oh;
    idx = out_ptr;
    if (total == 0 || idx >= total) begin
      load_ptr = 0;
      out_ptr = 0;
      r.value = '0;
      r.empty_window = 1'b1;
      r.last = 1'b1;
      return r;
    end
    c = idx % ch;
    pos = idx / ch;
    ox = pos % ow;
    oy = pos / ow;
    iw = in_reg[7:0];
    ih = in_reg[15:8];
    kw = kern_reg[7:0];
    kh = kern_reg[15:8];
    st = ox * strd_reg[7:0] - pad_reg[7:0];
    xlo = st < 0 ? 0 : st;
    xhi = st + kw > iw ? iw : st + kw;
    st = oy * strd_reg[15:8] - pad_reg[15:8];
    ylo = st < 0 ? 0 : st;
    yhi = st + kh > ih ? ih : st + kh;
    best = EMPTY_MAX_SEED;
    sum = 0;
    cnt = 0;
    for (int y = ylo; y < yhi; y++) begin
      for (int x = xlo; x < xhi; x++) begin
        int s;
        s = feat_mem[(c + ch * (x + y * iw)) % DEPTH];
        if (s > best) best = s;
        sum += s;
        cnt++;
      end
    end
    if (pool_mode == MODE_AVG) res = (cnt == 0) ? 0 : sum / cnt;
    else res = best;
    r.value = res[7:0];
    r.empty_window = (cnt == 0);
    r.last = (idx == total - 1);
    if (r.last) begin
      load_ptr = 0;
      out_ptr = 0;
    end else begin
      out_ptr = idx + 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Driver: the accepted transaction is predicted at the edge that takes it.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        if (item.operation == OP_LOAD) begin
          feat_mem[load_ptr] = item.sample;
          load_ptr = (load_ptr + 1) % DEPTH;
        end else begin
          pooled_expect.push_back(pool_pull());
        end
      end
      if (!item_valid || !item_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor with its own stall generator.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pooled_expect.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result);
          errors++;
        end else begin
          result_t e;
          e = pooled_expect.pop_front();
          if (e.value !== result.value || e.empty_window !== result.empty_window ||
              e.last !== result.last) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, result);
            errors++;
          end
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_left = 400;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MODE: pool_mode = mode_t'(val[0]);
      CFG_CHANNELS: chan_reg = val[7:0];
      CFG_IN_SIZE: in_reg = val;
      CFG_OUT_SIZE: out_reg = val;
      CFG_KERNEL: kern_reg = val;
      CFG_STRIDE: strd_reg = val;
      CFG_PAD: pad_reg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || item_valid || pooled_expect.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic setup_map(mode_t m, logic [7:0] ch, logic [15:0] isz, logic [15:0] osz,
                           logic [15:0] ksz, logic [15:0] ssz, logic [15:0] psz);
    wait_idle();
    write_reg(CFG_MODE, {15'd0, m});
    write_reg(CFG_CHANNELS, {8'd0, ch});
    write_reg(CFG_IN_SIZE, isz);
    write_reg(CFG_OUT_SIZE, osz);
    write_reg(CFG_KERNEL, ksz);
    write_reg(CFG_STRIDE, ssz);
    write_reg(CFG_PAD, psz);
  endtask

  task automatic push_item(op_t op, logic [7:0] s);
    item_t it;
    it.operation = op;
    it.sample = s;
    pending_items.push_back(it);
  endtask

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(5))
      0: return 8'h80;
      1: return 8'h7f;
      default: return 8'($urandom);
    endcase
  endfunction

  // Loads the input map (up to the store depth), then pulls every output, with optional noise.
  task automatic run_map(bit noisy);
    int n_load, n_out;
    n_load = chan_reg * in_reg[7:0] * in_reg[15:8];
    n_out = chan_reg * out_reg[7:0] * out_reg[15:8];
    if (n_load > DEPTH) n_load = DEPTH;
    for (int i = 0; i < n_load; i++) push_item(OP_LOAD, rand_sample());
    for (int i = 0; i < n_out; i++) begin
      push_item(OP_PULL, 8'($urandom));
      if (noisy && $urandom_range(9) == 0) push_item(OP_LOAD, rand_sample());
    end
    if (noisy && $urandom_range(4) == 0) push_item(OP_PULL, 8'($urandom));
  endtask

  initial begin
    int done;
    load_ptr = 0;
    out_ptr = 0;
    pool_mode = MODE_MAX;
    chan_reg = 8'd1;
    in_reg = 16'h0101;
    out_reg = 16'h0101;
    kern_reg = 16'h0101;
    strd_reg = 16'h0101;
    pad_reg = 16'h0000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 10;
    recv_stall_pct = 88;
    setup_map(MODE_MAX, 8'd2, 16'h0303, 16'h0202, 16'h0202, 16'h0101, 16'h0000);
    run_map(1'b0);
    setup_map(MODE_AVG, 8'd1, 16'h0303, 16'h0303, 16'h0303, 16'h0202, 16'h0101);
    run_map(1'b0);
    setup_map(MODE_MAX, 8'd1, 16'h0202, 16'h0202, 16'h0000, 16'h0101, 16'h0000);
    run_map(1'b0);
    setup_map(MODE_MAX, 8'd1, 16'h0101, 16'h0000, 16'h0101, 16'h0101, 16'h0000);
    push_item(OP_PULL, 8'h00);
    push_item(OP_PULL, 8'hff);
    setup_map(MODE_AVG, 8'd2, 16'hffff, 16'h0202, 16'h0303, 16'h0101, 16'hffff);
    for (int i = 0; i < 8; i++) push_item(OP_PULL, 8'($urandom));
    setup_map(MODE_MAX, 8'd3, 16'h0002, 16'h0202, 16'h0202, 16'h0000, 16'h00ff);
    run_map(1'b0);

    hold_req = 1'b1;
    done = 0;
    while (done < 375) begin
      if (done > 125) begin
        send_idle_pct = 88;
        recv_stall_pct = 10;
      end
      if (done > 250) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      setup_map(mode_t'($urandom_range(1)), 8'($urandom_range(1, 3)),
                {8'($urandom_range(1, 5)), 8'($urandom_range(1, 5))},
                {8'($urandom_range(1, 3)), 8'($urandom_range(1, 3))},
                {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))},
                {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))},
                {8'($urandom_range(0, 2)), 8'($urandom_range(0, 2))});
      run_map($urandom_range(3) == 0);
      done += pending_items.size();
    end

    while (pending_items.size() > 0 || item_valid || pooled_expect.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[pool_2d_q7_hwc_top.f]
rtl/core/p2d_pkg.sv
rtl/core/p2d_div.sv
rtl/core/pool_2d_q7_hwc_top.sv
rtl/core/p2d_chk.sv
verif/tb_pool_2d_q7_hwc_top.sv
